[rtl/core/h264_nal_rtp_packetizer_unit_assert.svh]
// assertion macros shared by the packetizer rtl
// expects signals named clk and rst_n in the including module
`ifndef H264_NAL_RTP_PACKETIZER_UNIT_ASSERT_SVH
`define H264_NAL_RTP_PACKETIZER_UNIT_ASSERT_SVH

// same-cycle implication, masked while in reset
`define HNRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define HNRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hnrp_pkg.sv]
// types and constants for the h264 nal to rtp packetizer
// no dependencies
package hnrp_pkg;

  localparam logic [7:0]  RTP_BYTE0   = 8'h80;  // version 2, no padding/ext/csrc
  localparam logic [4:0]  FU_A_TYPE   = 5'd28;
  localparam logic [10:0] MIN_PAYLOAD = 11'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // byte positions inside one packet command
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR_LAST = 4'd11;
  localparam logic [POS_W-1:0] POS_FU_IND   = 4'd12;
  localparam logic [POS_W-1:0] POS_FU_HDR   = 4'd13;
  localparam logic [POS_W-1:0] POS_PAY      = 4'd14;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TS_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SSRC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd3;

  // one queued unit of output work, at most one per accepted beat
  typedef struct packed {
    logic        hdr;     // 12-byte rtp header present
    logic        fu;      // fu indicator and fu header present
    logic        pay;     // one payload byte present
    logic        marker;
    logic        last;    // payload byte closes the packet
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/core/hnrp_if.sv]
// valid/ready channel interfaces for nal input and rtp output
// no dependencies
interface hnrp_in_if #(
  parameter int LENGTH_BITS = 17
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             nal_byte;
  logic                   nal_first;
  logic [LENGTH_BITS-1:0] nal_length;

  modport source (output valid, nal_byte, nal_first, nal_length, input ready);
  modport sink   (input valid, nal_byte, nal_first, nal_length, output ready);
endinterface

interface hnrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_first;
  logic       packet_last;

  modport source (output valid, out_byte, packet_first, packet_last, input ready);
  modport sink   (input valid, out_byte, packet_first, packet_last, output ready);
endinterface

[rtl/core/h264_nal_rtp_packetizer_unit.sv]
// top level of the h264 nal to rtp packetizer: config registers and wiring
// depends on hnrp_pkg, hnrp_if, hnrp_front, hnrp_queue, hnrp_back
// One NAL byte is taken per cycle while the four-entry command queue has room; each
// byte becomes one queued command, and the output serialiser sends one packet byte
// per cycle while commands wait and the output is ready. A plain NAL byte sends just
// itself; a byte that opens a packet is sent after the 12-byte header, the first FU-A
// fragment sends the header, FU indicator and FU header with no payload, and later
// fragments send all three plus the byte, so a packet with N payload bytes is N+12
// bytes long, or N+14 when fragmented. The output serialiser sets the sustained rate;
// the queue absorbs header bursts. A result byte passes the queue slot, then byte_r.
// A zero-length start, and a stray byte outside a NAL, produce no output.
module h264_nal_rtp_packetizer_unit #(
  parameter int LENGTH_BITS = 17
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hnrp_in_if.sink                          in_chan,
  hnrp_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [hnrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  logic [16:0] ts_step_r;
  logic [31:0] ssrc_r;
  logic [6:0]  pt_r;
  logic [10:0] max_pay_r;

  hnrp_pkg::qstat_t qstat;
  hnrp_pkg::cmd_t   push_cmd, head;
  logic             push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_step_r <= 17'd3600;
      ssrc_r    <= 32'd10;
      pt_r      <= 7'd96;
      max_pay_r <= 11'd1400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hnrp_pkg::CFG_TS_STEP: ts_step_r <= cfg_data[16:0];
        hnrp_pkg::CFG_SSRC:    ssrc_r    <= cfg_data;
        hnrp_pkg::CFG_PT:      pt_r      <= cfg_data[6:0];
        hnrp_pkg::CFG_MAX_PAY: max_pay_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  hnrp_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .ts_step     (ts_step_r),
    .max_payload (max_pay_r),
    .qstat       (qstat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  hnrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  hnrp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .qstat        (qstat),
    .ssrc         (ssrc_r),
    .payload_kind (pt_r),
    .pop          (pop),
    .out_chan     (out_chan)
  );

endmodule

[rtl/core/hnrp_front.sv]
// front end: accepts nal beats, tracks rtp/fragment state, queues commands
// depends on hnrp_pkg and hnrp_if
module hnrp_front #(
  parameter int LENGTH_BITS = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  hnrp_in_if.sink           in_chan,
  input  logic [16:0]       ts_step,
  input  logic [10:0]       max_payload,
  input  hnrp_pkg::qstat_t  qstat,
  output logic              push,
  output hnrp_pkg::cmd_t    push_cmd
);

  localparam int CW = (LENGTH_BITS > 11) ? LENGTH_BITS : 11;

  logic [15:0]            seq_r, seq_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [10:0]            fill_r, fill_nxt;
  logic                   frag_r, frag_nxt;

  logic                   accept;
  logic [10:0]            lim;
  logic [LENGTH_BITS-1:0] len;
  logic [7:0]             b;
  logic [10:0]            fill_v;
  logic                   is_last;

  assign in_chan.ready = !qstat.full;
  assign accept        = in_chan.valid && !qstat.full;
  assign lim           = (max_payload < hnrp_pkg::MIN_PAYLOAD) ? hnrp_pkg::MIN_PAYLOAD
                                                               : max_payload;
  assign len           = in_chan.nal_length;
  assign b             = in_chan.nal_byte;

  always_comb begin
    seq_nxt  = seq_r;
    ts_nxt   = ts_r;
    hdr_nxt  = hdr_r;
    rem_nxt  = rem_r;
    fill_nxt = fill_r;
    frag_nxt = frag_r;
    push     = 1'b0;
    push_cmd = '0;
    fill_v   = fill_r;
    is_last  = 1'b0;
    push_cmd.ts  = ts_r;
    push_cmd.seq = seq_r;
    if (accept) begin
      if (in_chan.nal_first) begin
        ts_nxt   = ts_r + {15'd0, ts_step};
        rem_nxt  = '0;
        fill_nxt = '0;
        frag_nxt = 1'b0;
        if (len != '0) begin
          hdr_nxt      = b;
          rem_nxt      = len - LENGTH_BITS'(1);
          seq_nxt      = seq_r + 16'd1;
          push         = 1'b1;
          push_cmd.hdr = 1'b1;
          push_cmd.seq = seq_r + 16'd1;
          push_cmd.ts  = ts_r + {15'd0, ts_step};
          if (CW'(len) <= CW'(lim)) begin
            push_cmd.pay  = 1'b1;
            push_cmd.data = b;
            push_cmd.last = (len == LENGTH_BITS'(1));
          end else begin
            frag_nxt        = 1'b1;
            fill_nxt        = 11'd1;
            push_cmd.fu     = 1'b1;
            push_cmd.fu_ind = {b[7:5], hnrp_pkg::FU_A_TYPE};
            push_cmd.fu_hdr = {1'b1, 1'b0, 1'b0, b[4:0]};
          end
        end
      end else if (rem_r != '0) begin
        push          = 1'b1;
        push_cmd.pay  = 1'b1;
        push_cmd.data = b;
        rem_nxt       = rem_r - LENGTH_BITS'(1);
        if (!frag_r) begin
          push_cmd.last = (rem_r == LENGTH_BITS'(1));
        end else begin
          // fragment full: open the next fu-a packet ahead of this byte
          if (fill_r >= lim) begin
            is_last         = (CW'(rem_r) <= CW'(lim));
            fill_v          = '0;
            seq_nxt         = seq_r + 16'd1;
            push_cmd.hdr    = 1'b1;
            push_cmd.seq    = seq_r + 16'd1;
            push_cmd.marker = is_last;
            push_cmd.fu     = 1'b1;
            push_cmd.fu_ind = {hdr_r[7:5], hnrp_pkg::FU_A_TYPE};
            push_cmd.fu_hdr = {1'b0, is_last, 1'b0, hdr_r[4:0]};
          end
          fill_v        = fill_v + 11'd1;
          push_cmd.last = (rem_r == LENGTH_BITS'(1)) || (fill_v >= lim);
          if (rem_r == LENGTH_BITS'(1)) begin
            frag_nxt = 1'b0;
            fill_nxt = '0;
          end else begin
            fill_nxt = fill_v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      hdr_r  <= '0;
      rem_r  <= '0;
      fill_r <= '0;
      frag_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      hdr_r  <= hdr_nxt;
      rem_r  <= rem_nxt;
      fill_r <= fill_nxt;
      frag_r <= frag_nxt;
    end
  end

endmodule

[rtl/core/hnrp_queue.sv]
// short command queue between front and back ends
// depends on hnrp_pkg and the assertion header
`include "h264_nal_rtp_packetizer_unit_assert.svh"

module hnrp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hnrp_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output hnrp_pkg::cmd_t   head,
  output hnrp_pkg::qstat_t stat
);

  hnrp_pkg::cmd_t                 slot_r [hnrp_pkg::QDEPTH];
  logic [hnrp_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [hnrp_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign head       = slot_r[rd_r];
  assign stat.full  = (count_r == hnrp_pkg::QCNT_W'(hnrp_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + hnrp_pkg::QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - hnrp_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + hnrp_pkg::QPTR_W'(1);
      if (pop)  rd_r <= rd_r + hnrp_pkg::QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `HNRP_ASSERT_IMP(a_no_overflow, push, !stat.full || pop, "push into a full queue")
  `HNRP_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from an empty queue")
  `HNRP_ASSERT_NXT(a_count_grows, push && !pop, count_r > $past(count_r), "count did not grow")

endmodule

[rtl/core/hnrp_back.sv]
// back end: serialises queued commands into rtp packet bytes
// depends on hnrp_pkg, hnrp_if and the assertion header
`include "h264_nal_rtp_packetizer_unit_assert.svh"

module hnrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hnrp_pkg::cmd_t   head,
  input  hnrp_pkg::qstat_t qstat,
  input  logic [31:0]      ssrc,
  input  logic [6:0]       payload_kind,
  output logic             pop,
  hnrp_out_if.source       out_chan
);

  logic [hnrp_pkg::POS_W-1:0] idx_r, idx_nxt, pos;
  logic                       valid_r;
  logic [7:0]                 byte_r, byte_c;
  logic                       first_r, last_r;
  logic                       advance, done;

  assign out_chan.valid        = valid_r;
  assign out_chan.out_byte     = byte_r;
  assign out_chan.packet_first = first_r;
  assign out_chan.packet_last  = last_r;

  assign advance = !qstat.empty && (!valid_r || out_chan.ready);
  // a payload-only command starts straight at the payload slot
  assign pos     = (idx_r == hnrp_pkg::POS_FIRST && !head.hdr) ? hnrp_pkg::POS_PAY : idx_r;
  assign done    = (pos == hnrp_pkg::POS_PAY) || (pos == hnrp_pkg::POS_FU_HDR && !head.pay);
  assign pop     = advance && done;

  always_comb begin
    case (pos)
      4'd0:    byte_c = hnrp_pkg::RTP_BYTE0;
      4'd1:    byte_c = {head.marker, payload_kind};
      4'd2:    byte_c = head.seq[15:8];
      4'd3:    byte_c = head.seq[7:0];
      4'd4:    byte_c = head.ts[31:24];
      4'd5:    byte_c = head.ts[23:16];
      4'd6:    byte_c = head.ts[15:8];
      4'd7:    byte_c = head.ts[7:0];
      4'd8:    byte_c = ssrc[31:24];
      4'd9:    byte_c = ssrc[23:16];
      4'd10:   byte_c = ssrc[15:8];
      4'd11:   byte_c = ssrc[7:0];
      4'd12:   byte_c = head.fu_ind;
      4'd13:   byte_c = head.fu_hdr;
      4'd14:   byte_c = head.data;
      default: byte_c = 8'h00;
    endcase
  end

  always_comb begin
    if (done) idx_nxt = hnrp_pkg::POS_FIRST;
    else if (pos == hnrp_pkg::POS_HDR_LAST && !head.fu) idx_nxt = hnrp_pkg::POS_PAY;
    else idx_nxt = pos + hnrp_pkg::POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r  <= byte_c;
      first_r <= (pos == hnrp_pkg::POS_FIRST);
      last_r  <= (pos == hnrp_pkg::POS_PAY) && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= hnrp_pkg::POS_FIRST;
      valid_r <= 1'b0;
    end else begin
      if (advance) idx_r <= idx_nxt;
      if (advance) valid_r <= 1'b1;
      else if (out_chan.ready) valid_r <= 1'b0;
    end
  end

  `HNRP_ASSERT_IMP(a_fu_slot, !qstat.empty && idx_r == hnrp_pkg::POS_FU_IND, head.fu,
                   "fu slot reached on a command without fu bytes")
  `HNRP_ASSERT_IMP(a_hdr_walk, !qstat.empty && idx_r != hnrp_pkg::POS_FIRST, head.hdr,
                   "header walk on a payload-only command")

endmodule
